FILE: rtl/hrp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrp_pkg
// Types and constants shared by the hex record parser front end, back end
// and top level.
// ----------------------------------------------------------------------------
package hrp_pkg;

  localparam logic [7:0] ASCII_COLON = 8'h3a;
  localparam logic [7:0] ASCII_CR    = 8'h0d;
  localparam logic [7:0] ASCII_LF    = 8'h0a;

  localparam logic [7:0] RTYPE_DATA = 8'h00;
  localparam logic [7:0] RTYPE_END  = 8'h01;

  typedef enum logic [2:0] {
    TOK_HEX   = 3'd0,
    TOK_COLON = 3'd1,
    TOK_CR    = 3'd2,
    TOK_LF    = 3'd3,
    TOK_OTHER = 3'd4,
    TOK_END   = 3'd5
  } tok_e;

  typedef struct packed {
    tok_e       cls;
    logic [3:0] nib;
  } tok_t;

  typedef enum logic [2:0] {
    KIND_DATA    = 3'd0,
    KIND_GOOD    = 3'd1,
    KIND_BAD     = 3'd2,
    KIND_END     = 3'd3,
    KIND_INVALID = 3'd4
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [15:0] addr;
    logic [7:0]  data;
    logic [16:0] extent;
  } res_t;

  typedef enum logic [9:0] {
    ST_IDLE   = 10'b00_0000_0001,
    ST_COUNT  = 10'b00_0000_0010,
    ST_ADDR   = 10'b00_0000_0100,
    ST_TYPE   = 10'b00_0000_1000,
    ST_DATA   = 10'b00_0001_0000,
    ST_CSUM   = 10'b00_0010_0000,
    ST_EOL    = 10'b00_0100_0000,
    ST_EOL_LF = 10'b00_1000_0000,
    ST_SKIP   = 10'b01_0000_0000,
    ST_DONE   = 10'b10_0000_0000
  } state_e;

endpackage

FILE: rtl/hrp_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrp_fifo
// Two-entry first-word-fall-through queue built from two registers.
// ----------------------------------------------------------------------------
module hrp_fifo #(
  parameter int unsigned Width = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             empty_o
);

  logic [1:0]       cnt_q, cnt_d;
  logic [Width-1:0] slot0_q, slot1_q;
  logic             push_ok, pop_ok;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign data_o  = slot0_q;
  assign push_ok = push_i & ~full_o;
  assign pop_ok  = pop_i & ~empty_o;

  always_comb begin
    cnt_d = cnt_q;
    if (push_ok & ~pop_ok) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop_ok & ~push_ok) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_ok) begin
      slot0_q <= (cnt_q == 2'd2) ? slot1_q : data_i;
    end else if (push_ok && cnt_q == 2'd0) begin
      slot0_q <= data_i;
    end
    if (push_ok && cnt_q == 2'd1 && !pop_ok) begin
      slot1_q <= data_i;
    end
  end

endmodule

FILE: rtl/hrp_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrp_front
// Accepts characters, classifies each one into a token and queues it for
// the record parser.
// ----------------------------------------------------------------------------
module hrp_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  output logic          full_o,
  input  logic [7:0]    symbol_i,
  input  logic          stream_end_i,
  output logic          tok_valid_o,
  output hrp_pkg::tok_t tok_o,
  input  logic          tok_pop_i
);
  import hrp_pkg::*;

  tok_t tok_in;
  logic tok_empty;

  always_comb begin
    tok_in.cls = TOK_OTHER;
    tok_in.nib = 4'd0;
    if (stream_end_i) begin
      tok_in.cls = TOK_END;
    end else if (symbol_i >= 8'h30 && symbol_i <= 8'h39) begin
      tok_in.cls = TOK_HEX;
      tok_in.nib = symbol_i[3:0];
    end else if ((symbol_i >= 8'h41 && symbol_i <= 8'h46) ||
                 (symbol_i >= 8'h61 && symbol_i <= 8'h66)) begin
      tok_in.cls = TOK_HEX;
      tok_in.nib = symbol_i[3:0] + 4'd9;
    end else if (symbol_i == ASCII_COLON) begin
      tok_in.cls = TOK_COLON;
    end else if (symbol_i == ASCII_CR) begin
      tok_in.cls = TOK_CR;
    end else if (symbol_i == ASCII_LF) begin
      tok_in.cls = TOK_LF;
    end
  end

  hrp_fifo #(
    .Width($bits(tok_t))
  ) u_tok_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push_i),
    .data_i (tok_in),
    .full_o (full_o),
    .pop_i  (tok_pop_i),
    .data_o (tok_o),
    .empty_o(tok_empty)
  );

  assign tok_valid_o = ~tok_empty;

endmodule

FILE: rtl/hrp_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrp_back
// Record parser state machine: consumes one token per cycle while the result
// queue has room, queueing data writes, checksum, end record and invalid reports.
// ----------------------------------------------------------------------------
module hrp_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          tok_valid_i,
  input  hrp_pkg::tok_t tok_i,
  output logic          tok_pop_o,
  output logic          res_empty_o,
  input  logic          res_pop_i,
  output hrp_pkg::res_t res_o
);
  import hrp_pkg::*;

  state_e      state_q, state_d;
  logic [1:0]  nib_q, nib_d;
  logic [15:0] acc_q, acc_d;
  logic [7:0]  len_q, len_d;
  logic [15:0] addr_q, addr_d;
  logic [15:0] wa_q, wa_d;
  logic [7:0]  sum_q, sum_d;
  logic [7:0]  left_q, left_d;
  logic [16:0] ext_q, ext_d;

  logic        take, res_full, res_we, clear_all, field_done;
  logic [15:0] acc_next;
  logic [7:0]  fbyte;
  res_t        res_in;

  assign take      = tok_valid_i & ~res_full;
  assign tok_pop_o = take;
  assign acc_next  = {acc_q[11:0], tok_i.nib};
  assign fbyte     = acc_next[7:0];

  always_comb begin
    state_d    = state_q;
    nib_d      = nib_q;
    acc_d      = acc_q;
    len_d      = len_q;
    addr_d     = addr_q;
    wa_d       = wa_q;
    sum_d      = sum_q;
    left_d     = left_q;
    ext_d      = ext_q;
    res_we     = 1'b0;
    res_in     = '0;
    clear_all  = 1'b0;
    field_done = (state_q == ST_ADDR) ? (nib_q == 2'd3) : (nib_q == 2'd1);

    if (take) begin
      if (tok_i.cls == TOK_END) begin
        clear_all = 1'b1;
        if (state_q != ST_DONE) begin
          res_we      = 1'b1;
          res_in.kind = KIND_INVALID;
        end
      end else begin
        case (state_q)
          ST_DONE: begin
          end
          ST_EOL: begin
            if (tok_i.cls == TOK_LF) begin
              state_d = ST_IDLE;
            end else if (tok_i.cls == TOK_CR) begin
              state_d = ST_EOL_LF;
            end else begin
              clear_all   = 1'b1;
              res_we      = 1'b1;
              res_in.kind = KIND_INVALID;
            end
          end
          ST_EOL_LF: begin
            if (tok_i.cls == TOK_LF) begin
              state_d = ST_IDLE;
            end else begin
              clear_all   = 1'b1;
              res_we      = 1'b1;
              res_in.kind = KIND_INVALID;
            end
          end
          ST_SKIP: begin
            if (tok_i.cls == TOK_CR) begin
              state_d = ST_EOL_LF;
            end else if (tok_i.cls == TOK_LF) begin
              state_d = ST_IDLE;
            end
          end
          ST_COUNT, ST_ADDR, ST_TYPE, ST_DATA, ST_CSUM: begin
            if (tok_i.cls != TOK_HEX) begin
              clear_all   = 1'b1;
              res_we      = 1'b1;
              res_in.kind = KIND_INVALID;
            end else begin
              acc_d = acc_next;
              nib_d = nib_q + 2'd1;
              if (field_done) begin
                acc_d = 16'd0;
                nib_d = 2'd0;
                case (state_q)
                  ST_COUNT: begin
                    len_d   = fbyte;
                    sum_d   = sum_q + fbyte;
                    state_d = ST_ADDR;
                  end
                  ST_ADDR: begin
                    addr_d  = acc_next;
                    sum_d   = sum_q + acc_next[15:8] + acc_next[7:0];
                    state_d = ST_TYPE;
                  end
                  ST_TYPE: begin
                    sum_d = sum_q + fbyte;
                    if (fbyte == RTYPE_END) begin
                      res_we        = 1'b1;
                      res_in.kind   = KIND_END;
                      res_in.extent = ext_q;
                      clear_all     = 1'b1;
                    end else if (fbyte == RTYPE_DATA) begin
                      ext_d   = {1'b0, addr_q} + {9'd0, len_q};
                      left_d  = len_q;
                      wa_d    = addr_q;
                      state_d = (len_q != 8'd0) ? ST_DATA : ST_CSUM;
                    end else begin
                      state_d = ST_SKIP;
                    end
                  end
                  ST_DATA: begin
                    res_we      = 1'b1;
                    res_in.kind = KIND_DATA;
                    res_in.addr = wa_q;
                    res_in.data = fbyte;
                    sum_d       = sum_q + fbyte;
                    left_d      = left_q - 8'd1;
                    wa_d        = wa_q + 16'd1;
                    state_d     = (left_q != 8'd1) ? ST_DATA : ST_CSUM;
                  end
                  default: begin
                    res_we      = 1'b1;
                    res_in.kind = ((sum_q + fbyte) == 8'd0) ? KIND_GOOD : KIND_BAD;
                    state_d     = ST_EOL;
                  end
                endcase
              end
            end
          end
          default: begin
            if (tok_i.cls == TOK_COLON) begin
              sum_d   = 8'd0;
              nib_d   = 2'd0;
              acc_d   = 16'd0;
              state_d = ST_COUNT;
            end else begin
              clear_all   = 1'b1;
              res_we      = 1'b1;
              res_in.kind = KIND_INVALID;
            end
          end
        endcase
      end
    end

    if (clear_all) begin
      state_d = (res_we && res_in.kind == KIND_END) ? ST_DONE : ST_IDLE;
      nib_d   = 2'd0;
      acc_d   = 16'd0;
      len_d   = 8'd0;
      addr_d  = 16'd0;
      wa_d    = 16'd0;
      sum_d   = 8'd0;
      left_d  = 8'd0;
      ext_d   = 17'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      nib_q   <= 2'd0;
      acc_q   <= 16'd0;
      len_q   <= 8'd0;
      addr_q  <= 16'd0;
      wa_q    <= 16'd0;
      sum_q   <= 8'd0;
      left_q  <= 8'd0;
      ext_q   <= 17'd0;
    end else begin
      state_q <= state_d;
      nib_q   <= nib_d;
      acc_q   <= acc_d;
      len_q   <= len_d;
      addr_q  <= addr_d;
      wa_q    <= wa_d;
      sum_q   <= sum_d;
      left_q  <= left_d;
      ext_q   <= ext_d;
    end
  end

  hrp_fifo #(
    .Width($bits(res_t))
  ) u_res_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_we),
    .data_i (res_in),
    .full_o (res_full),
    .pop_i  (res_pop_i),
    .data_o (res_o),
    .empty_o(res_empty_o)
  );

endmodule

FILE: rtl/hex_record_parser_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hex_record_parser_top
// Intel HEX text parser: one character in, memory writes and record status
// out.
// ----------------------------------------------------------------------------
// Characters are taken at one per cycle whenever full is low. Each one is
// classified and held in a two-entry token queue; the parser state machine
// handles one token per cycle while its two-entry result queue has room, so
// a result is held in the token queue and then in the result queue before it
// can be popped. Sustained rate is one character per cycle as long as results
// are popped as fast as they are made.
// ----------------------------------------------------------------------------
module hex_record_parser_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  symbol_i,
  input  logic        stream_end_i,
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  kind_o,
  output logic [15:0] write_address_o,
  output logic [7:0]  write_data_o,
  output logic [16:0] extent_o
);
  import hrp_pkg::*;

  logic tok_valid, tok_pop;
  tok_t tok;
  res_t res;

  hrp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .full_o      (full),
    .symbol_i    (symbol_i),
    .stream_end_i(stream_end_i),
    .tok_valid_o (tok_valid),
    .tok_o       (tok),
    .tok_pop_i   (tok_pop)
  );

  hrp_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .tok_valid_i(tok_valid),
    .tok_i      (tok),
    .tok_pop_o  (tok_pop),
    .res_empty_o(empty),
    .res_pop_i  (pop),
    .res_o      (res)
  );

  assign kind_o          = res.kind;
  assign write_address_o = res.addr;
  assign write_data_o    = res.data;
  assign extent_o        = res.extent;

  a_kind_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (kind_o <= KIND_INVALID))
    else $error("result kind out of range");

  a_non_data_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && kind_o != KIND_DATA) |-> (write_address_o == 16'd0 && write_data_o == 8'd0))
    else $error("write fields set on a non-data item");

  a_extent_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && kind_o != KIND_END) |-> (extent_o == 17'd0))
    else $error("extent set on an item that is not an end record");

  a_tok_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tok_pop |-> tok_valid)
    else $error("token taken from an empty queue");

endmodule
